// File: sv/dpoa_pkg.sv
// Shared types and constants for the dust pulse occupancy averager.
`default_nettype none
package dpoa_pkg;
	localparam int unsigned LEVEL_W      = 11;
	localparam int unsigned COUNT_W      = 16;
	localparam int unsigned SLOT_W       = 8;
	localparam int unsigned TIMER_W      = 16;
	localparam int unsigned COUNT_CAP    = 250;
	localparam int unsigned LEVEL_MAX    = 2047;
	localparam int unsigned WARMUP_RESET = 60000;
	localparam int unsigned STUCK_RESET  = 10000;

	// Register indexes on the configuration port
	localparam int unsigned REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_WARMUP = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_STUCK  = 1'd1;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SUM  = 6'b000010,
		ST_DIV  = 6'b000100,
		ST_FIN  = 6'b001000,
		ST_TICK = 6'b010000,
		ST_OUT  = 6'b100000
	} dpoa_state_t;
endpackage
`default_nettype wire

// File: sv/dust_pulse_occupancy_averager.sv
// Top level of the dust pulse occupancy averager: sequencer, shared adder and register file.
`default_nettype none
// One input transaction is one 1 ms tick carrying the supply state, the pulse pin level and a
// window-end strobe; each tick yields exactly one result transaction (PM2.5 level, raw level,
// fault flag). A plain tick goes from acceptance through the tick update to the result
// load, which waits until the output register is free. A tick that closes a window while
// warmed up and with the pin high also runs the window work through one shared add/subtract
// unit: it sums the slots (up to SLOT_COUNT), then, while the ring is still filling, runs a
// restoring division (one quotient bit a cycle, ACC_W = 11 quotient bits at SLOT_COUNT = 5)
// and then scales and saturates. in_ready is high only while the sequencer is idle; the
// output register lets the next tick be accepted while the previous result still waits.
// No clearing pass is needed after reset. Registers: warmup_ticks at byte address 0 and
// stuck_low_ticks at byte address 4, both 16 bits in the low half of the 32-bit data word;
// a new value takes effect at the next timer reload (the first powered-off tick, and for
// stuck_low_ticks also any powered, warmed-up tick with the pin high).
module dust_pulse_occupancy_averager
	import dpoa_pkg::*;
#(
	parameter int unsigned SLOT_COUNT = 5
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// configuration port
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [2:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output logic      [31:0]         prdata,
	output logic                     pready,
	// tick channel
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic                power_on,
	input  wire logic                sensor_low,
	input  wire logic                window_end,
	// result channel
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [LEVEL_W-1:0]       pm25_level,
	output logic [LEVEL_W-1:0]       raw_level,
	output logic                     sensor_fault
);
	// widths that follow from the slot count
	localparam int unsigned PTR_W  = $clog2(SLOT_COUNT + 1);
	localparam int unsigned SIDX_W = $clog2(SLOT_COUNT);
	localparam int unsigned ACC_W  = $clog2(SLOT_COUNT * COUNT_CAP + 1);
	localparam int unsigned UW     = ACC_W + 1;
	localparam int unsigned BIT_W  = $clog2(ACC_W);
	localparam int unsigned TW     = (ACC_W > LEVEL_W) ? ACC_W : LEVEL_W;
	localparam logic [PTR_W-1:0] SC_PTR  = PTR_W'(SLOT_COUNT);
	localparam logic [ACC_W-1:0] SC_ACC  = ACC_W'(SLOT_COUNT);
	localparam logic [BIT_W-1:0] BIT_TOP = BIT_W'(ACC_W - 1);

	// configuration registers
	logic [TIMER_W-1:0] warmup_ticks_q;
	logic [TIMER_W-1:0] stuck_low_ticks_q;

	// block state
	dpoa_state_t        state_q;
	logic [COUNT_W-1:0] pulse_count_q;
	logic [SLOT_W-1:0]  slots_q [SLOT_COUNT];
	logic [PTR_W-1:0]   slot_ptr_q;
	logic               ring_full_q;
	logic [LEVEL_W-1:0] level_q;
	logic [TIMER_W-1:0] warmup_left_q;
	logic [TIMER_W-1:0] stuck_left_q;
	logic               off_handled_q;

	// captured tick and window-work registers
	logic               power_q;
	logic               low_q;
	logic [PTR_W-1:0]   used_q;
	logic [SIDX_W-1:0]  idx_q;
	logic [ACC_W-1:0]   acc_q;
	logic [ACC_W-1:0]   quo_q;
	logic [PTR_W-1:0]   rem_q;
	logic [BIT_W-1:0]   bit_q;

	// output register
	logic               out_valid_q;
	logic [LEVEL_W-1:0] pm25_q;
	logic [LEVEL_W-1:0] raw_q;
	logic               fault_q;

	logic               cfg_wr;
	logic [REG_IDX_W-1:0] cfg_idx;
	logic               in_acc;
	logic               out_free;
	logic [PTR_W-1:0]   wr_ptr;
	logic [SLOT_W-1:0]  capped;
	logic [PTR_W-1:0]   last_idx;
	logic [PTR_W:0]     shifted;
	logic               unit_sub;
	logic [UW-1:0]      unit_a;
	logic [UW-1:0]      unit_b;
	logic [UW-1:0]      unit_res;
	logic               div_ge;
	logic [ACC_W-1:0]   scaled;
	logic [TW-1:0]      total;
	logic [LEVEL_W-1:0] level_sat;

	// ---------------------------------------------------------------------
	// Configuration port: zero wait states, write in the access phase
	// ---------------------------------------------------------------------
	assign pready  = 1'b1;
	assign cfg_idx = paddr[2:2];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_comb begin
		case (cfg_idx)
			REG_WARMUP: prdata = {16'd0, warmup_ticks_q};
			REG_STUCK:  prdata = {16'd0, stuck_low_ticks_q};
			default:    prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warmup_ticks_q    <= TIMER_W'(WARMUP_RESET);
			stuck_low_ticks_q <= TIMER_W'(STUCK_RESET);
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_WARMUP: warmup_ticks_q    <= pwdata[TIMER_W-1:0];
				REG_STUCK:  stuck_low_ticks_q <= pwdata[TIMER_W-1:0];
				default:    ;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Handshakes
	// ---------------------------------------------------------------------
	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid & in_ready;
	assign out_free  = ~out_valid_q | out_ready;

	// Slot to write at window close; the pointer is always wrapped, guard anyway
	assign wr_ptr   = (slot_ptr_q >= SC_PTR) ? '0 : slot_ptr_q;
	assign capped   = (pulse_count_q > COUNT_W'(COUNT_CAP)) ? SLOT_W'(COUNT_CAP)
	                                                         : pulse_count_q[SLOT_W-1:0];
	// Last slot summed: whole ring once full, else the filled slots
	assign last_idx = ring_full_q ? (SC_PTR - 1'b1) : (used_q - 1'b1);

	// ---------------------------------------------------------------------
	// Shared add/subtract unit: slot sum, then division trial subtract
	// ---------------------------------------------------------------------
	assign shifted = {rem_q, quo_q[ACC_W-1]};

	always_comb begin
		unit_sub = (state_q == ST_DIV);
		if (unit_sub) begin
			unit_a = UW'(shifted);
			unit_b = UW'(used_q);
		end else begin
			unit_a = UW'(acc_q);
			unit_b = UW'(slots_q[idx_q]);
		end
		unit_res = unit_a + (unit_b ^ {UW{unit_sub}}) + UW'(unit_sub);
	end

	assign div_ge = ~unit_res[UW-1];

	// Scale the partial mean back up, or take the full-ring sum, then saturate
	assign scaled    = quo_q * SC_ACC;
	assign total     = ring_full_q ? TW'(acc_q) : TW'(scaled);
	assign level_sat = (total > TW'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX) : total[LEVEL_W-1:0];

	// ---------------------------------------------------------------------
	// Sequencer and block state
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			pulse_count_q <= '0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				slots_q[i] <= '0;
			end
			slot_ptr_q    <= '0;
			ring_full_q   <= 1'b0;
			level_q       <= '0;
			warmup_left_q <= TIMER_W'(WARMUP_RESET);
			stuck_left_q  <= TIMER_W'(STUCK_RESET);
			off_handled_q <= 1'b0;
			power_q       <= 1'b0;
			low_q         <= 1'b0;
			used_q        <= '0;
			idx_q         <= '0;
			acc_q         <= '0;
			quo_q         <= '0;
			rem_q         <= '0;
			bit_q         <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						power_q <= power_on;
						low_q   <= sensor_low;
						state_q <= ST_TICK;
						// Window close runs before the tick is sampled
						if (window_end) begin
							if (sensor_low) begin
								slot_ptr_q  <= '0;
								ring_full_q <= 1'b0;
							end else if (warmup_left_q == '0) begin
								slots_q[wr_ptr[SIDX_W-1:0]] <= capped;
								pulse_count_q <= '0;
								used_q        <= wr_ptr + 1'b1;
								idx_q         <= '0;
								acc_q         <= '0;
								state_q       <= ST_SUM;
							end
						end
					end
				end
				ST_SUM: begin
					acc_q <= unit_res[ACC_W-1:0];
					idx_q <= idx_q + 1'b1;
					if (PTR_W'(idx_q) == last_idx) begin
						if (ring_full_q) begin
							state_q <= ST_FIN;
						end else begin
							// load the dividend, quotient bits shift in from the bottom
							quo_q   <= unit_res[ACC_W-1:0];
							rem_q   <= '0;
							bit_q   <= BIT_TOP;
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					rem_q <= div_ge ? unit_res[PTR_W-1:0] : shifted[PTR_W-1:0];
					quo_q <= {quo_q[ACC_W-2:0], div_ge};
					bit_q <= bit_q - 1'b1;
					if (bit_q == '0) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					level_q <= level_sat;
					if (!ring_full_q && used_q == SC_PTR) begin
						ring_full_q <= 1'b1;
					end
					slot_ptr_q <= (used_q == SC_PTR) ? '0 : used_q;
					state_q    <= ST_TICK;
				end
				ST_TICK: begin
					state_q <= ST_OUT;
					if (!power_q) begin
						// Reload the timers and clear the count, level and slots on the first powered-off tick only
						if (!off_handled_q) begin
							pulse_count_q <= '0;
							level_q       <= '0;
							warmup_left_q <= warmup_ticks_q;
							stuck_left_q  <= stuck_low_ticks_q;
							for (int i = 0; i < SLOT_COUNT; i++) begin
								slots_q[i] <= '0;
							end
							off_handled_q <= 1'b1;
						end
					end else begin
						off_handled_q <= 1'b0;
						if (warmup_left_q != '0) begin
							warmup_left_q <= warmup_left_q - 1'b1;
						end else if (low_q) begin
							if (pulse_count_q != '1) begin
								pulse_count_q <= pulse_count_q + 1'b1;
							end
							if (stuck_left_q != '0) begin
								stuck_left_q <= stuck_left_q - 1'b1;
							end
						end else begin
							stuck_left_q <= stuck_low_ticks_q;
						end
					end
				end
				ST_OUT: begin
					// Hold until the output register can take the result
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Output register
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			raw_q   <= level_q;
			fault_q <= (stuck_left_q == '0);
			pm25_q  <= (stuck_left_q == '0) ? '0 : level_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign pm25_level   = pm25_q;
	assign raw_level    = raw_q;
	assign sensor_fault = fault_q;
endmodule
`default_nettype wire

// File: sv/dpoa_checker.sv
// Port-level checker for the dust pulse occupancy averager and its bind.
`default_nettype none
module dpoa_checker
	import dpoa_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic [LEVEL_W-1:0] pm25_level,
	input wire logic [LEVEL_W-1:0] raw_level,
	input wire logic               sensor_fault
);
	// A stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pm25_level)
			&& $stable(raw_level) && $stable(sensor_fault))
		else $error("result changed while stalled");

	// A fault forces the PM2.5 level to zero
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sensor_fault |-> pm25_level == '0)
		else $error("PM2.5 level not zero under fault");

	// Without a fault both levels agree
	a_levels_agree: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !sensor_fault |-> pm25_level == raw_level)
		else $error("PM2.5 and raw level differ without fault");

	// The level never exceeds its saturation value
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> raw_level <= LEVEL_W'(LEVEL_MAX))
		else $error("raw level above saturation");
endmodule

bind dust_pulse_occupancy_averager dpoa_checker u_dpoa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.pm25_level   (pm25_level),
	.raw_level    (raw_level),
	.sensor_fault (sensor_fault)
);
`default_nettype wire
